FILE: design/tsc_pkg.sv
// tsc_pkg: shared widths, constants and register indexes of the thermistor scan conditioner
`default_nettype none

package tsc_pkg;

  // scan geometry
  localparam int BankCount    = 16;
  localparam int CellsPerBank = 8;
  localparam int CellTotal    = BankCount * CellsPerBank;
  localparam int CntWidth     = (CellTotal > 1) ? $clog2(CellTotal) : 1;
  localparam int IdxWidth     = 7;
  localparam logic [IdxWidth-1:0] LastIndex = IdxWidth'((CellTotal - 1) % (2 ** IdxWidth));

  // field widths
  localparam int RawWidth    = 16;
  localparam int LimitWidth  = 15;
  localparam int TolWidth    = 8;
  localparam int TempWidth   = 14;  // converted value, at most 15014
  localparam int Temp10Width = 11;  // converted value over ten
  localparam int SumWidth    = 22;
  localparam int MinWidth    = 16;
  localparam int MaxWidth    = 15;
  localparam int MaxOutWidth = 12;
  localparam int MinOutWidth = 13;
  localparam int Y9Width     = 16;  // 74240 - 9v on the steep segment
  localparam int Y81Width    = 20;  // 1178000 - 81v on the shallow segment

  // piecewise linear breakpoints and constants
  localparam logic [RawWidth-1:0]  BreakSat     = 16'd1576;
  localparam logic [RawWidth-1:0]  BreakSteep   = 16'd4700;
  localparam logic [RawWidth-1:0]  BreakShallow = 16'd14436;
  localparam logic [TempWidth-1:0] TempSat      = 14'd15000;
  localparam logic [Temp10Width-1:0] Temp10Sat  = 11'd1500;
  // steep segment peaks just past the first knee, slightly above the flat part
  localparam logic [TempWidth-1:0] TempMax      = 14'd15014;
  localparam logic [Temp10Width-1:0] Temp10Max  = 11'd1501;
  localparam int SteepBase   = 74240;
  localparam int SteepSlope  = 9;
  localparam int ShallowBase = 1178000;
  localparam int ShallowSlope = 81;

  // reciprocal multipliers: floor(x/d) = (x * ceil(2^k/d)) >> k, k = width(x) + clog2(d)
  localparam int  Div40Shift   = Y9Width + $clog2(40);
  localparam longint Div40Mul  = ((64'd1 << Div40Shift) + 40 - 1) / 40;
  localparam int  Div100Shift  = Y81Width + $clog2(100);
  localparam longint Div100Mul = ((64'd1 << Div100Shift) + 100 - 1) / 100;
  localparam int  Div1kShift   = Y81Width + $clog2(1000);
  localparam longint Div1kMul  = ((64'd1 << Div1kShift) + 1000 - 1) / 1000;
  localparam int  MaxDivShift  = MaxWidth + $clog2(10);
  localparam longint MaxDivMul = ((64'd1 << MaxDivShift) + 10 - 1) / 10;
  localparam int  MinDivShift  = MinWidth + $clog2(10);
  localparam longint MinDivMul = ((64'd1 << MinDivShift) + 10 - 1) / 10;
  localparam int  MeanDiv      = 10 * CellTotal;
  localparam int  MeanShift    = SumWidth + $clog2(MeanDiv);
  localparam longint MeanMul   = ((64'd1 << MeanShift) + MeanDiv - 1) / MeanDiv;
  localparam int  MulWidth     = 24;  // each multiplier above fits in this

  // accumulator reset values
  localparam logic [MinWidth-1:0] MinReset = 16'd65000;
  localparam logic [TolWidth-1:0] ErrCountMax = 8'd255;

  // configuration port
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 16;
  localparam logic [CfgIdxWidth-1:0] CfgAdcOffset   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgUnderLimit  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgOverLimit   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgErrTol      = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgMaxValidLim = 3'd4;

  localparam logic [RawWidth-1:0]   OffsetReset   = 16'd0;
  localparam logic [LimitWidth-1:0] UnderReset    = 15'd0;
  localparam logic [LimitWidth-1:0] OverReset     = 15'd6000;
  localparam logic [TolWidth-1:0]   TolReset      = 8'd1;
  localparam logic [LimitWidth-1:0] MaxValidReset = 15'd1500;

endpackage

`default_nettype wire

FILE: design/thermistor_scan_conditioner.sv
// thermistor_scan_conditioner: per-cell thermistor conversion with per-scan aggregates
//
// One raw ADC sample enters per request on the input channel (in_valid_i / in_stall_o),
// in scan order. Each request produces one result on the output channel
// (out_valid_o / out_stall_i): cell index, temperature in tenths of a degree and the
// cell error flag. On the last cell of a scan, scan_done_o is high and mean, max, min
// and pack error are valid; on other cells they read zero.
// Five register stages: input, segment select, conversion, accumulate, output. One request
// is taken every cycle while the output is not stalled. Each stage holds its item only
// while the stage after it is full and blocked, so a stalled output still lets earlier
// stages fill; in_stall_o rises once all five stages hold items.
// Configuration writes (cfg_valid_i / cfg_ready_o, always ready) are registered and
// are to be made while no request is in flight.
// Reset empties the pipeline, loads the register defaults and clears the scan counter
// and accumulators.
`default_nettype none

module thermistor_scan_conditioner import tsc_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // sample requests
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [RawWidth-1:0]      raw_sample_i,
  // results
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [IdxWidth-1:0]           cell_index_o,
  output logic [Temp10Width-1:0]        cell_temp_o,
  output logic                          cell_error_o,
  output logic                          scan_done_o,
  output logic [Temp10Width-1:0]        mean_temp_o,
  output logic [MaxOutWidth-1:0]        max_temp_o,
  output logic [MinOutWidth-1:0]        min_temp_o,
  output logic                          pack_error_o,
  // configuration writes
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CfgIdxWidth-1:0]   cfg_index_i,
  input  wire logic [CfgDataWidth-1:0]  cfg_data_i
);

  typedef enum logic [1:0] {
    RGN_SAT,
    RGN_STEEP,
    RGN_SHALLOW,
    RGN_OPEN
  } region_e;

  // configuration registers
  logic [RawWidth-1:0]   offset_q;
  logic [LimitWidth-1:0] under_q;
  logic [LimitWidth-1:0] over_q;
  logic [TolWidth-1:0]   tol_q;
  logic [LimitWidth-1:0] max_valid_q;

  // stage valids
  logic in_vld_q, pre_vld_q, conv_vld_q, cell_vld_q, out_vld_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // stage payloads
  logic [RawWidth-1:0]    raw_q;
  region_e                rgn_d, rgn_q;
  logic [Y9Width-1:0]     y9_d, y9_q;
  logic [Y81Width-1:0]    y81_d, y81_q;
  logic [TempWidth-1:0]   t_d, t_q;
  logic [Temp10Width-1:0] t10_d, t10_q;

  logic [IdxWidth-1:0]    c_idx_q;
  logic [Temp10Width-1:0] c_t10_q;
  logic                   c_err_q, c_last_q, c_pack_q;
  logic [SumWidth-1:0]    c_sum_q;
  logic [MaxWidth-1:0]    c_max_q;
  logic [MinWidth-1:0]    c_min_q;

  logic [IdxWidth-1:0]    o_idx_q;
  logic [Temp10Width-1:0] o_t10_q, o_mean_q;
  logic                   o_err_q, o_last_q, o_pack_q;
  logic [MaxOutWidth-1:0] o_max_q;
  logic [MinOutWidth-1:0] o_min_q;

  // accumulators
  logic [CntWidth-1:0]    cnt_q;
  logic [SumWidth-1:0]    sum_q;
  logic [MinWidth-1:0]    min_q;
  logic [MaxWidth-1:0]    max_q;
  logic [TolWidth-1:0]    ecnt_q;

  // ready chain from the output back to the input
  assign rdy5 = !out_vld_q || !out_stall_i;
  assign rdy4 = !cell_vld_q || rdy5;
  assign rdy3 = !conv_vld_q || rdy4;
  assign rdy2 = !pre_vld_q || rdy3;
  assign rdy1 = !in_vld_q || rdy2;
  assign in_stall_o  = !rdy1;
  assign cfg_ready_o = 1'b1;

  // segment select and linear numerators
  logic [RawWidth-1:0] v;
  logic [19:0]         y9_full;
  logic [23:0]         y81_full;

  always_comb begin
    v        = raw_q + offset_q;
    y9_full  = 20'(SteepBase) - 20'(v) * 20'(SteepSlope);
    y81_full = 24'(ShallowBase) - 24'(v) * 24'(ShallowSlope);
    y9_d     = y9_full[Y9Width-1:0];
    y81_d    = y81_full[Y81Width-1:0];
    priority if (v < BreakSat) begin
      rgn_d = RGN_SAT;
    end else if (v < BreakSteep) begin
      rgn_d = RGN_STEEP;
    end else if (v < BreakShallow) begin
      rgn_d = RGN_SHALLOW;
    end else begin
      rgn_d = RGN_OPEN;
    end
  end

  // constant division by reciprocal multiplication
  logic [Y9Width+MulWidth-1:0]  p40;
  logic [Y81Width+MulWidth-1:0] p100, p1k;

  always_comb begin
    p40  = (Y9Width+MulWidth)'(y9_q) * (Y9Width+MulWidth)'(Div40Mul);
    p100 = (Y81Width+MulWidth)'(y81_q) * (Y81Width+MulWidth)'(Div100Mul);
    p1k  = (Y81Width+MulWidth)'(y81_q) * (Y81Width+MulWidth)'(Div1kMul);
    unique case (rgn_q)
      RGN_SAT: begin
        t_d   = TempSat;
        t10_d = Temp10Sat;
      end
      RGN_STEEP: begin
        t_d   = TempWidth'(y9_q >> 2);
        t10_d = Temp10Width'(p40 >> Div40Shift);
      end
      RGN_SHALLOW: begin
        t_d   = TempWidth'(p100 >> Div100Shift);
        t10_d = Temp10Width'(p1k >> Div1kShift);
      end
      default: begin
        t_d   = '0;
        t10_d = '0;
      end
    endcase
  end

  // cell checks and accumulator update
  logic                     err, last, pack;
  logic [SumWidth:0]        sum_ext;
  logic [SumWidth-1:0]      sum_new;
  logic [MinWidth-1:0]      min_new;
  logic [MaxWidth-1:0]      max_new;
  logic [TolWidth-1:0]      ecnt_new;
  logic [CntWidth+IdxWidth-1:0] idx_ext;

  always_comb begin
    err     = !((LimitWidth'(t_q) > under_q) && (LimitWidth'(t_q) < over_q));
    last    = (cnt_q == CntWidth'(CellTotal - 1));
    sum_ext = (SumWidth+1)'(sum_q) + (SumWidth+1)'(t_q);
    sum_new = sum_ext[SumWidth] ? '1 : sum_ext[SumWidth-1:0];
    min_new = ((t_q != '0) && (MinWidth'(t_q) < min_q)) ? MinWidth'(t_q) : min_q;
    max_new = ((MaxWidth'(t_q) > max_q) && (LimitWidth'(t_q) < max_valid_q)) ?
              MaxWidth'(t_q) : max_q;
    ecnt_new = (err && (ecnt_q != ErrCountMax)) ? ecnt_q + 1'b1 : ecnt_q;
    pack     = (ecnt_new >= tol_q);
    idx_ext  = (CntWidth+IdxWidth)'(cnt_q);
  end

  // aggregate scaling on the scan-end snapshot
  logic [SumWidth+MulWidth-1:0] pmean;
  logic [MaxWidth+MulWidth-1:0] pmax;
  logic [MinWidth+MulWidth-1:0] pmin;

  always_comb begin
    pmean = (SumWidth+MulWidth)'(c_sum_q) * (SumWidth+MulWidth)'(MeanMul);
    pmax  = (MaxWidth+MulWidth)'(c_max_q) * (MaxWidth+MulWidth)'(MaxDivMul);
    pmin  = (MinWidth+MulWidth)'(c_min_q) * (MinWidth+MulWidth)'(MinDivMul);
  end

  // control state, configuration and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      pre_vld_q   <= 1'b0;
      conv_vld_q  <= 1'b0;
      cell_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
      offset_q    <= OffsetReset;
      under_q     <= UnderReset;
      over_q      <= OverReset;
      tol_q       <= TolReset;
      max_valid_q <= MaxValidReset;
      cnt_q       <= '0;
      sum_q       <= '0;
      min_q       <= MinReset;
      max_q       <= '0;
      ecnt_q      <= '0;
    end else begin
      if (rdy1) in_vld_q   <= in_valid_i;
      if (rdy2) pre_vld_q  <= in_vld_q;
      if (rdy3) conv_vld_q <= pre_vld_q;
      if (rdy4) cell_vld_q <= conv_vld_q;
      if (rdy5) out_vld_q  <= cell_vld_q;

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgAdcOffset:   offset_q    <= cfg_data_i;
          CfgUnderLimit:  under_q     <= cfg_data_i[LimitWidth-1:0];
          CfgOverLimit:   over_q      <= cfg_data_i[LimitWidth-1:0];
          CfgErrTol:      tol_q       <= cfg_data_i[TolWidth-1:0];
          CfgMaxValidLim: max_valid_q <= cfg_data_i[LimitWidth-1:0];
          default: ;
        endcase
      end

      if (conv_vld_q && rdy4) begin
        if (last) begin
          cnt_q  <= '0;
          sum_q  <= '0;
          min_q  <= MinReset;
          max_q  <= '0;
          ecnt_q <= '0;
        end else begin
          cnt_q  <= cnt_q + 1'b1;
          sum_q  <= sum_new;
          min_q  <= min_new;
          max_q  <= max_new;
          ecnt_q <= ecnt_new;
        end
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      raw_q <= raw_sample_i;
    end
    if (rdy2 && in_vld_q) begin
      rgn_q <= rgn_d;
      y9_q  <= y9_d;
      y81_q <= y81_d;
    end
    if (rdy3 && pre_vld_q) begin
      t_q   <= t_d;
      t10_q <= t10_d;
    end
    if (rdy4 && conv_vld_q) begin
      c_idx_q  <= idx_ext[IdxWidth-1:0];
      c_t10_q  <= t10_q;
      c_err_q  <= err;
      c_last_q <= last;
      c_sum_q  <= sum_new;
      c_max_q  <= max_new;
      c_min_q  <= min_new;
      c_pack_q <= pack;
    end
    if (rdy5 && cell_vld_q) begin
      o_idx_q  <= c_idx_q;
      o_t10_q  <= c_t10_q;
      o_err_q  <= c_err_q;
      o_last_q <= c_last_q;
      o_mean_q <= c_last_q ? Temp10Width'(pmean >> MeanShift) : '0;
      o_max_q  <= c_last_q ? MaxOutWidth'(pmax >> MaxDivShift) : '0;
      o_min_q  <= c_last_q ? MinOutWidth'(pmin >> MinDivShift) : '0;
      o_pack_q <= c_last_q && c_pack_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign cell_index_o = o_idx_q;
  assign cell_temp_o  = o_t10_q;
  assign cell_error_o = o_err_q;
  assign scan_done_o  = o_last_q;
  assign mean_temp_o  = o_mean_q;
  assign max_temp_o   = o_max_q;
  assign min_temp_o   = o_min_q;
  assign pack_error_o = o_pack_q;

  // accumulators sit at their cleared values whenever a new scan is about to start
  a_scan_start_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (sum_q == '0) && (max_q == '0) && (min_q == MinReset) &&
                      (ecnt_q == '0))
    else $error("accumulators not cleared at scan start");

  // aggregates only on the last cell of a scan
  a_aggr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !o_last_q) |-> (o_mean_q == '0) && (o_max_q == '0) &&
                                 (o_min_q == '0) && !o_pack_q)
    else $error("aggregate fields set on a cell that does not end the scan");

  // the scan ends on the final cell index
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && o_last_q) |-> (o_idx_q == LastIndex))
    else $error("scan end flagged on the wrong cell");

  // converted temperature never exceeds the peak of the steep segment
  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_vld_q |-> (t_q <= TempMax) && (t10_q <= Temp10Max))
    else $error("converted temperature out of range");

endmodule

`default_nettype wire

FILE: tb/sv/thermistor_scan_checker.sv
// thermistor_scan_checker: predicts per-cell and per-scan results and compares them
`timescale 1ns / 1ps

module thermistor_scan_checker import tsc_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // sample requests
  input  wire logic                    in_valid_i,
  input  wire logic                    in_stall_i,
  input  wire logic [RawWidth-1:0]     raw_sample_i,
  // results
  input  wire logic                    out_valid_i,
  input  wire logic                    out_stall_i,
  input  wire logic [IdxWidth-1:0]     cell_index_i,
  input  wire logic [Temp10Width-1:0]  cell_temp_i,
  input  wire logic                    cell_error_i,
  input  wire logic                    scan_done_i,
  input  wire logic [Temp10Width-1:0]  mean_temp_i,
  input  wire logic [MaxOutWidth-1:0]  max_temp_i,
  input  wire logic [MinOutWidth-1:0]  min_temp_i,
  input  wire logic                    pack_error_i,
  // configuration writes
  input  wire logic                    cfg_valid_i,
  input  wire logic                    cfg_ready_i,
  input  wire logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i,
  // status for the test top
  output int                           fail_count_o,
  output int                           pending_o
);

  localparam int SumLimit = (1 << SumWidth) - 1;

  typedef struct packed {
    logic [IdxWidth-1:0]    index;
    logic [Temp10Width-1:0] temp;
    logic                   error;
    logic                   done;
    logic [Temp10Width-1:0] mean;
    logic [MaxOutWidth-1:0] hottest;
    logic [MinOutWidth-1:0] coldest;
    logic                   pack;
  } cell_report_t;

  // register copies
  logic [RawWidth-1:0]   offset;
  logic [LimitWidth-1:0] under;
  logic [LimitWidth-1:0] over;
  logic [TolWidth-1:0]   tolerance;
  logic [LimitWidth-1:0] max_valid;

  // scan accumulators
  int cells_seen;
  int sum_acc;
  int min_acc;
  int max_acc;
  int err_acc;

  cell_report_t due_reports[$];
  int mismatches;

  // piecewise linear conversion to hundredths of a degree
  function automatic int level_to_centideg(input logic [RawWidth-1:0] level);
    int v;
    v = int'(level);
    if (v < 1576) return 15000;
    if (v < 4700) return (74240 - 9 * v) / 4;
    if (v < 14436) return (1178000 - 81 * v) / 100;
    return 0;
  endfunction

  function automatic void clear_scan();
    cells_seen = 0;
    sum_acc = 0;
    min_acc = int'(MinReset);
    max_acc = 0;
    err_acc = 0;
  endfunction

  // convert one sample, fold it into the scan and build its report
  function automatic cell_report_t account_cell(input logic [RawWidth-1:0] raw);
    logic [RawWidth-1:0] level;
    int t;
    logic bad;
    logic last;
    cell_report_t r;
    level = raw + offset;
    t = level_to_centideg(level);
    bad = !(t > int'(under) && t < int'(over));
    last = (cells_seen + 1) >= CellTotal;
    sum_acc = (sum_acc + t > SumLimit) ? SumLimit : sum_acc + t;
    if (t != 0 && t < min_acc) min_acc = t;
    if (t > max_acc && t < int'(max_valid)) max_acc = t;
    if (bad && err_acc < int'(ErrCountMax)) err_acc++;
    r = '0;
    r.index = IdxWidth'(cells_seen);
    r.temp = Temp10Width'(t / 10);
    r.error = bad;
    r.done = last;
    if (last) begin
      r.mean = Temp10Width'((sum_acc / CellTotal) / 10);
      r.hottest = MaxOutWidth'(max_acc / 10);
      r.coldest = MinOutWidth'(min_acc / 10);
      r.pack = (err_acc >= int'(tolerance));
      clear_scan();
    end else begin
      cells_seen++;
    end
    return r;
  endfunction

  task automatic check_field(input string label, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cell_report_t want;
    if (!rst_ni) begin
      offset = OffsetReset;
      under = UnderReset;
      over = OverReset;
      tolerance = TolReset;
      max_valid = MaxValidReset;
      clear_scan();
      due_reports.delete();
      mismatches = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgAdcOffset:   offset = cfg_data_i;
          CfgUnderLimit:  under = cfg_data_i[LimitWidth-1:0];
          CfgOverLimit:   over = cfg_data_i[LimitWidth-1:0];
          CfgErrTol:      tolerance = cfg_data_i[TolWidth-1:0];
          CfgMaxValidLim: max_valid = cfg_data_i[LimitWidth-1:0];
          default: ;
        endcase
      end
      // compare an accepted result with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (due_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual cell %0d", $time,
                   cell_index_i);
          mismatches++;
        end else begin
          want = due_reports.pop_front();
          check_field("cell_index", want.index, cell_index_i);
          check_field("cell_temp", want.temp, cell_temp_i);
          check_field("cell_error", want.error, cell_error_i);
          check_field("scan_done", want.done, scan_done_i);
          check_field("mean_temp", want.mean, mean_temp_i);
          check_field("max_temp", want.hottest, max_temp_i);
          check_field("min_temp", want.coldest, min_temp_i);
          check_field("pack_error", want.pack, pack_error_i);
        end
      end
      // predict for an accepted request
      if (in_valid_i && !in_stall_i) begin
        due_reports.push_back(account_cell(raw_sample_i));
      end
      pending_o <= due_reports.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

FILE: tb/sv/thermistor_scan_conditioner_test.sv
// thermistor_scan_conditioner_test: stimulus, flow control and verdict for the scan conditioner
`timescale 1ns / 1ps

module thermistor_scan_conditioner_test import tsc_pkg::*; ();

  localparam int CycleLimit = 300000;
  localparam int PhaseCount = 6;
  localparam int PhaseItems = 305;
  localparam int CornerCount = 25;
  localparam logic [CfgIdxWidth-1:0] CfgFirstUnused = CfgMaxValidLim + 3'd1;

  // levels around the breakpoints and the extremes of the sample
  localparam logic [RawWidth*CornerCount-1:0] CornerLevels = {
    16'd0, 16'd1, 16'd1575, 16'd1576, 16'd1577, 16'd3000, 16'd4699, 16'd4700,
    16'd4701, 16'd9000, 16'd14435, 16'd14436, 16'd14437, 16'h5555, 16'hAAAA,
    16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFE, 16'd2024, 16'd7000, 16'd1200,
    16'd13000, 16'd100, 16'd4000
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [RawWidth-1:0]     raw_sample = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [IdxWidth-1:0]     cell_index;
  logic [Temp10Width-1:0]  cell_temp;
  logic                    cell_error;
  logic                    scan_done;
  logic [Temp10Width-1:0]  mean_temp;
  logic [MaxOutWidth-1:0]  max_temp;
  logic [MinOutWidth-1:0]  min_temp;
  logic                    pack_error;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CfgIdxWidth-1:0]  cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int cycles = 0;

  thermistor_scan_conditioner uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .raw_sample_i (raw_sample),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .cell_index_o (cell_index),
    .cell_temp_o  (cell_temp),
    .cell_error_o (cell_error),
    .scan_done_o  (scan_done),
    .mean_temp_o  (mean_temp),
    .max_temp_o   (max_temp),
    .min_temp_o   (min_temp),
    .pack_error_o (pack_error),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  thermistor_scan_checker scan_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .raw_sample_i (raw_sample),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .cell_index_i (cell_index),
    .cell_temp_i  (cell_temp),
    .cell_error_i (cell_error),
    .scan_done_i  (scan_done),
    .mean_temp_i  (mean_temp),
    .max_temp_i   (max_temp),
    .min_temp_i   (min_temp),
    .pack_error_i (pack_error),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // register settings per phase: offset, under, over, tolerance, max valid
  // upper bits beyond each register width are set in some phases to check masking
  function automatic logic [5*CfgDataWidth-1:0] phase_settings(input int phase);
    case (phase)
      0:       return {16'h0000, 16'h8000, 16'd6000, 16'hFF01, 16'd1500};
      1:       return {16'h8000, 16'h7FFF, 16'h7FFF, 16'h00FF, 16'h7FFF};
      2:       return {16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
      3:       return {16'hFC18, 16'd1000, 16'd12000, 16'd20, 16'd9000};
      4:       return {16'd500, 16'd2000, 16'd15001, 16'd64, 16'd15001};
      default: return {16'h0000, 16'd14999, 16'hFFFF, 16'h0180, 16'h9388};
    endcase
  endfunction

  // level after offset, spread over the segments and their knees
  function automatic logic [RawWidth-1:0] pick_level();
    logic [RawWidth-1:0] knee;
    case ($urandom_range(0, 7))
      0: return RawWidth'($urandom_range(0, 1575));
      1: return RawWidth'($urandom_range(1576, 4699));
      2: return RawWidth'($urandom_range(4700, 14435));
      3: return RawWidth'($urandom_range(14436, 65535));
      4: begin
        case ($urandom_range(0, 2))
          0:       knee = BreakSat;
          1:       knee = BreakSteep;
          default: knee = BreakShallow;
        endcase
        return knee + RawWidth'($urandom_range(0, 4)) - 16'd2;
      end
      default: return RawWidth'($urandom);
    endcase
  endfunction

  // hold a request until it is taken
  task automatic offer_sample(input logic [RawWidth-1:0] raw);
    in_valid <= 1'b1;
    raw_sample <= raw;
    do @(posedge clk); while (in_stall);
  endtask

  // wait for every result, then let the pipeline settle
  task automatic drain();
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CfgIdxWidth-1:0] index,
                         input logic [CfgDataWidth-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(input logic [5*CfgDataWidth-1:0] s);
    put_reg(CfgAdcOffset, s[79:64]);
    put_reg(CfgUnderLimit, s[63:48]);
    put_reg(CfgOverLimit, s[47:32]);
    put_reg(CfgErrTol, s[31:16]);
    put_reg(CfgMaxValidLim, s[15:0]);
    // index past the register list, must be ignored
    put_reg(CfgFirstUnused + CfgIdxWidth'($urandom_range(0, 2)), CfgDataWidth'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // random samples in bursts with gaps between them
  task automatic run_samples(input int count, input logic [RawWidth-1:0] offset);
    int burst;
    int gap;
    burst = $urandom_range(1, 40);
    for (int n = 0; n < count; n++) begin
      offer_sample(pick_level() - offset);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;
  endtask

  // receiver stall pattern, with one long hold-off while requests are offered
  initial begin : receiver
    int mode;
    int span;
    bit pressed;
    pressed = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 9);
      if (!pressed && in_valid) begin
        mode = 9;
        pressed = 1'b1;
      end
      span = (mode == 9) ? $urandom_range(120, 250) : $urandom_range(5, 60);
      repeat (span) begin
        case (mode)
          0, 1, 2, 3: out_stall <= 1'b0;
          4, 5, 6, 7: out_stall <= ($urandom_range(0, 1) == 1);
          8:          out_stall <= ($urandom_range(0, 4) != 0);
          default:    out_stall <= 1'b1;
        endcase
        @(posedge clk);
      end
    end
  end

  // reset, directed corners, then random phases over several settings
  initial begin : stimulus
    logic [5*CfgDataWidth-1:0] settings;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int k = 0; k < CornerCount; k++) begin
      offer_sample(CornerLevels[RawWidth*k +: RawWidth]);
    end
    in_valid <= 1'b0;
    drain();
    for (int p = 0; p < PhaseCount; p++) begin
      settings = phase_settings(p);
      apply_settings(settings);
      run_samples(PhaseItems, settings[79:64]);
      drain();
    end
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
